// ===== hw/rtl/gwsn_pkg.sv =====
package gwsn_pkg;

   localparam int DIV_W  = 48;
   localparam int DVS_W  = 32;
   localparam int QUO_W  = 49;
   localparam int STEP_W = 6;
   localparam int SUM_W  = 48;
   localparam int WGT_W  = 14;
   localparam int ACC_W  = SUM_W + WGT_W;
   localparam int OWN_W  = 33;

   localparam logic [4:0]  RADIUS_CAP = 5'd16;
   localparam logic [7:0]  GREY_FULL  = 8'hff;
   localparam logic signed [QUO_W-1:0] ONE_Q16 = 49'sd65536;

   localparam logic [1:0] CSR_RADIUS  = 2'd0;
   localparam logic [1:0] CSR_COLUMNS = 2'd1;
   localparam logic [1:0] CSR_USE_EXT = 2'd2;
   localparam logic [1:0] CSR_EXT_MAX = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hw/rtl/grid_weighted_spread_normalize_top.sv =====
// Loads a grid one cell per item in raster order (one item per cycle); the item marked last
// starts the spread, which holds the input while it reads each cell, visits each window
// position around each source ((2*radius-1)^2 positions) and divides each weighted cell,
// all paced by the single read port of each cell memory and the bit-per-cycle 48-step
// divider. A read item waits on that divider unless the divisor is zero; a read before the
// spread has finished, or past the loaded cells, gives no item.
module grid_weighted_spread_normalize_top #(
   parameter int MAX_CELLS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // own_value, is_source, cell_index
   input  logic        req_tuser,   // op
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_index, normalized_value, grey_level, painted
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);
   import gwsn_pkg::*;

   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CW = $clog2(MAX_CELLS + 1);
   localparam int SW = CW + 12;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SC_RD    = 4'd1;
   localparam logic [3:0] ST_SC_CHK   = 4'd2;
   localparam logic [3:0] ST_WN_RD    = 4'd3;
   localparam logic [3:0] ST_WN_WR    = 4'd4;
   localparam logic [3:0] ST_DV_RD    = 4'd5;
   localparam logic [3:0] ST_DV_START = 4'd6;
   localparam logic [3:0] ST_DV_WAIT  = 4'd7;
   localparam logic [3:0] ST_RD_WAIT  = 4'd8;
   localparam logic [3:0] ST_RD_DIV   = 4'd9;
   localparam logic [3:0] ST_RD_OUT   = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [4:0]            radius_ff;
   logic [6:0]            cols_ff;
   logic                  use_ext_ff;
   logic [30:0]           ext_max_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic                  computed_ff, computed_in;
   logic [31:0]           found_max_ff, found_max_in;
   logic [CW-1:0]         i_ff, i_in;
   logic [CW-1:0]         row_ff, row_in;
   logic [6:0]            col_ff, col_in;
   logic signed [31:0]    own_i_ff, own_i_in;
   logic signed [5:0]     dr_ff, dr_in, dc_ff, dc_in;
   logic signed [SW-1:0]  jbase_ff, jbase_in;
   logic [AW-1:0]         j_ff, j_in;
   logic signed [47:0]    prod_ff, prod_in;
   logic [WGT_W-1:0]      w_ff, w_in;
   logic signed [31:0]    avg_ff, avg_in;
   logic signed [17:0]    nv_ff, nv_in;
   logic [11:0]           idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [39:0]           rsp_data_ff, rsp_data_in;

   logic                  own_we, acc_we;
   logic [AW-1:0]         own_waddr, own_raddr, acc_waddr, acc_raddr;
   logic [OWN_W-1:0]      own_wdata, own_rdata;
   logic [ACC_W-1:0]      acc_wdata, acc_rdata;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  req_fire;
   logic signed [31:0]    req_own;
   logic                  req_src;
   logic [11:0]           req_idx;
   logic [CW-1:0]         load_addr;
   logic [4:0]            rad_eff, rad_m1;
   logic [6:0]            cols_eff;
   logic signed [5:0]     span;
   logic signed [SW-1:0]  nr, j_s;
   logic signed [8:0]     nc;
   logic                  win_ok;
   logic [5:0]            adr, adc, dmax;
   logic [4:0]            fw;
   logic [11:0]           off12;
   logic signed [SUM_W-1:0] acc_sum;
   logic [WGT_W-1:0]      acc_w;
   logic [31:0]           q_mag, divisor;
   logic signed [QUO_W-1:0] q;
   logic [24:0]           grey_prod;
   logic [7:0]            grey;

   function automatic logic signed [17:0] sat_q1(input logic signed [QUO_W-1:0] v);
      if (v > ONE_Q16) begin
         return 18'sd65536;
      end else if (v < -ONE_Q16) begin
         return -18'sd65536;
      end
      return v[17:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign req_own    = req_tdata[31:0];
   assign req_src    = req_tdata[32];
   assign req_idx    = req_tdata[44:33];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= 5'd5;
         cols_ff    <= 7'd64;
         use_ext_ff <= 1'b0;
         ext_max_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RADIUS:  radius_ff  <= csr_data[4:0];
            CSR_COLUMNS: cols_ff    <= csr_data[6:0];
            CSR_USE_EXT: use_ext_ff <= csr_data[0];
            CSR_EXT_MAX: ext_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rad_eff  = (radius_ff > RADIUS_CAP) ? RADIUS_CAP : radius_ff;
      rad_m1   = rad_eff - 5'd1;
      cols_eff = (cols_ff == 7'd0) ? 7'd1 : cols_ff;
      span     = $signed({1'b0, rad_m1});
      nr       = SW'($signed({1'b0, row_ff})) + SW'(dr_ff);
      nc       = 9'($signed({1'b0, col_ff})) + 9'(dc_ff);
      j_s      = jbase_ff + SW'(dc_ff);
      win_ok   = !nr[SW-1] && !nc[8] && (nc < $signed({2'b0, cols_eff}))
                 && (j_s < $signed(SW'({1'b0, count_ff})));
      adr      = dr_ff[5] ? 6'(-dr_ff) : dr_ff;
      adc      = dc_ff[5] ? 6'(-dc_ff) : dc_ff;
      dmax     = (adr > adc) ? adr : adc;
      fw       = rad_eff - dmax[4:0];
      off12    = 12'(rad_m1) * 12'(cols_eff);
      acc_sum  = acc_rdata[SUM_W-1:0];
      acc_w    = acc_rdata[ACC_W-1:SUM_W];
      load_addr = computed_ff ? '0 : count_ff;
      q        = div_rsp.quotient;
      q_mag    = q[QUO_W-1] ? 32'(-q) : q[31:0];
      divisor  = use_ext_ff ? {1'b0, ext_max_ff} : found_max_ff;
      grey_prod = 25'(nv_ff[16:0]) * 25'(GREY_FULL);
      grey     = (avg_ff != 0 && nv_ff > 0) ? grey_prod[23:16] : 8'd0;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      computed_in  = computed_ff;
      found_max_in = found_max_ff;
      i_in         = i_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      own_i_in     = own_i_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      jbase_in     = jbase_ff;
      j_in         = j_ff;
      prod_in      = prod_ff;
      w_in         = w_ff;
      avg_in       = avg_ff;
      nv_in        = nv_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      own_we       = 1'b0;
      acc_we       = 1'b0;
      own_waddr    = load_addr[AW-1:0];
      own_wdata    = {req_src, req_own};
      own_raddr    = i_ff[AW-1:0];
      acc_waddr    = load_addr[AW-1:0];
      acc_wdata    = req_src ? {WGT_W'(1), SUM_W'(req_own)} : '0;
      acc_raddr    = i_ff[AW-1:0];
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            acc_raddr = AW'(32'(req_idx));
            if (req_fire && req_tuser == OP_LOAD) begin
               if (computed_ff || count_ff < CW'(MAX_CELLS)) begin
                  own_we   = 1'b1;
                  acc_we   = 1'b1;
                  count_in = load_addr + 1'b1;
               end
               computed_in = 1'b0;
               if (req_tlast) begin
                  found_max_in = '0;
                  i_in         = '0;
                  row_in       = '0;
                  col_in       = '0;
                  state_in     = ST_SC_RD;
               end
            end else if (req_fire && req_tuser == OP_READ) begin
               idx_in = req_idx;
               if (computed_ff && 32'(req_idx) < 32'(count_ff)) begin
                  state_in = ST_RD_WAIT;
               end
            end
         end
         ST_SC_RD: begin
            if (i_ff == count_ff) begin
               i_in     = '0;
               state_in = ST_DV_RD;
            end else begin
               state_in = ST_SC_CHK;
            end
         end
         ST_SC_CHK: begin
            own_i_in = own_rdata[31:0];
            if (own_rdata[32] && rad_eff > 5'd1) begin
               dr_in    = -span;
               dc_in    = -span;
               jbase_in = SW'($signed({1'b0, i_ff})) - $signed(SW'(off12));
               state_in = ST_WN_RD;
            end else begin
               i_in = i_ff + 1'b1;
               if (col_ff == cols_eff - 7'd1) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 7'd1;
               end
               state_in = ST_SC_RD;
            end
         end
         ST_WN_RD, ST_WN_WR: begin
            own_raddr = j_s[AW-1:0];
            acc_raddr = j_s[AW-1:0];
            j_in      = j_s[AW-1:0];
            prod_in   = 48'($signed({1'b0, fw})) * 48'(own_i_ff);
            acc_waddr = j_ff;
            acc_wdata = {acc_w + WGT_W'(fw), acc_sum + prod_ff};
            if (state_ff == ST_WN_RD && win_ok) begin
               state_in = ST_WN_WR;
            end else begin
               acc_we = (state_ff == ST_WN_WR) && !own_rdata[32];
               state_in = ST_WN_RD;
               if (dc_ff == span) begin
                  if (dr_ff == span) begin
                     i_in = i_ff + 1'b1;
                     if (col_ff == cols_eff - 7'd1) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 7'd1;
                     end
                     state_in = ST_SC_RD;
                  end else begin
                     dr_in    = dr_ff + 6'sd1;
                     dc_in    = -span;
                     jbase_in = jbase_ff + SW'(cols_eff);
                  end
               end else begin
                  dc_in = dc_ff + 6'sd1;
               end
            end
         end
         ST_DV_RD: begin
            if (i_ff == count_ff) begin
               computed_in = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_DV_START;
            end
         end
         ST_DV_START: begin
            w_in = acc_w;
            if (acc_w == '0) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_DV_RD;
            end else begin
               div_req.start    = 1'b1;
               div_req.neg      = acc_sum[SUM_W-1];
               div_req.dividend = acc_sum[SUM_W-1] ? DIV_W'(-acc_sum) : acc_sum;
               div_req.divisor  = DVS_W'(acc_w);
               state_in         = ST_DV_WAIT;
            end
         end
         ST_DV_WAIT: begin
            acc_waddr = i_ff[AW-1:0];
            acc_wdata = {w_ff, SUM_W'($signed(q[31:0]))};
            if (div_rsp.done) begin
               acc_we = 1'b1;
               if (q_mag > found_max_ff) begin
                  found_max_in = q_mag;
               end
               i_in     = i_ff + 1'b1;
               state_in = ST_DV_RD;
            end
         end
         ST_RD_WAIT: begin
            avg_in = acc_sum[31:0];
            if (divisor == '0) begin
               nv_in    = sat_q1(QUO_W'($signed(acc_sum[31:0])));
               state_in = ST_RD_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.neg      = acc_sum[31];
               div_req.dividend = {(acc_sum[31] ? 32'(-acc_sum[31:0]) : acc_sum[31:0]),
                                   16'b0};
               div_req.divisor  = divisor;
               state_in         = ST_RD_DIV;
            end
         end
         ST_RD_DIV: begin
            if (div_rsp.done) begin
               nv_in    = sat_q1(q);
               state_in = ST_RD_OUT;
            end
         end
         ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, avg_ff != 0, grey, nv_ff, idx_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         computed_ff  <= 1'b0;
         found_max_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         computed_ff  <= computed_in;
         found_max_ff <= found_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      own_i_ff    <= own_i_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      jbase_ff    <= jbase_in;
      j_ff        <= j_in;
      prod_ff     <= prod_in;
      w_ff        <= w_in;
      avg_ff      <= avg_in;
      nv_ff       <= nv_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   gwsn_ram #(.WIDTH(OWN_W), .DEPTH(MAX_CELLS)) u_own_ram (
      .clock (clock),
      .we    (own_we),
      .waddr (own_waddr),
      .wdata (own_wdata),
      .raddr (own_raddr),
      .rdata (own_rdata)
   );

   gwsn_ram #(.WIDTH(ACC_W), .DEPTH(MAX_CELLS)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   gwsn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

`ifndef ASSERT_OFF
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == ST_DV_START || state_ff == ST_RD_WAIT))
      else $error("divider started outside a divide step");
   a_computed_cells: assert property (@(posedge clock) disable iff (reset)
      computed_ff |-> count_ff != '0)
      else $error("grid marked computed with no cells");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RD_OUT)
      else $error("result raised outside the output step");
`endif
endmodule

// ===== hw/rtl/gwsn_ram.sv =====
module gwsn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/gwsn_div.sv =====
module gwsn_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gwsn_pkg::div_req_type req,
   output gwsn_pkg::div_rsp_type rsp
);
   import gwsn_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.neg;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = DVS_W'(ge ? (trial - {1'b0, dvs_ff}) : trial);
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
endmodule

// ===== verif/gwsn_checker.sv =====
`timescale 1ns / 100ps

module gwsn_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data,
   output int          mismatch_count,
   output int          pending_count
);
   import gwsn_pkg::*;

   typedef struct packed {
      logic        painted;
      logic [7:0]  grey;
      logic [17:0] norm;
      logic [11:0] index;
   } cell_result_type;

   logic signed [31:0] cell_value [4096];
   bit                 cell_src   [4096];
   longint             cell_avg   [4096];
   int                 cell_wgt   [4096];
   int                 cell_count;
   longint             found_max;
   bit                 computed;

   logic [4:0]  radius;
   logic [6:0]  columns;
   logic        use_ext;
   logic [30:0] ext_max;

   cell_result_type expected_cells [$];

   assign pending_count = expected_cells.size();

   function automatic int chebyshev(int a, int b);
      int x;
      int y;
      x = a < 0 ? -a : a;
      y = b < 0 ? -b : b;
      return x > y ? x : y;
   endfunction

   function automatic void spread_grid();
      int     rad;
      int     cols;
      int     row;
      int     col;
      int     nr;
      int     nc;
      int     j;
      longint f;
      longint mag;
      rad  = radius > RADIUS_CAP ? RADIUS_CAP : radius;
      cols = columns != 0 ? columns : 1;
      for (int i = 0; i < cell_count; i++) begin
         cell_avg[i] = cell_src[i] ? longint'(cell_value[i]) : 0;
         cell_wgt[i] = cell_src[i] ? 1 : 0;
      end
      for (int i = 0; i < cell_count; i++) begin
         if (cell_src[i]) begin
            row = i / cols;
            col = i % cols;
            for (int dr = 1 - rad; dr <= rad - 1; dr++) begin
               nr = row + dr;
               if (nr >= 0) begin
                  for (int dc = 1 - rad; dc <= rad - 1; dc++) begin
                     nc = col + dc;
                     j  = nr * cols + nc;
                     if (nc >= 0 && nc < cols && j < cell_count && !cell_src[j]) begin
                        f = rad - chebyshev(dr, dc);
                        cell_avg[j] += f * longint'(cell_value[i]);
                        cell_wgt[j] = (cell_wgt[j] + int'(f)) & 16'hffff;
                     end
                  end
               end
            end
         end
      end
      found_max = 0;
      for (int i = 0; i < cell_count; i++) begin
         if (cell_wgt[i] != 0) begin
            cell_avg[i] = cell_avg[i] / longint'(cell_wgt[i]);
            mag = cell_avg[i] < 0 ? -cell_avg[i] : cell_avg[i];
            if (mag > found_max) found_max = mag & 64'hffff_ffff;
         end
      end
      computed = 1;
   endfunction

   function automatic void predict_read(logic [11:0] idx);
      longint          avg;
      longint          dvs;
      longint          nv;
      longint          grey;
      cell_result_type r;
      if (computed && idx < cell_count) begin
         avg = cell_avg[idx];
         dvs = use_ext ? longint'(ext_max) : found_max;
         nv  = dvs != 0 ? (avg * 65536) / dvs : avg;
         if (nv > 65536) nv = 65536;
         if (nv < -65536) nv = -65536;
         grey = 0;
         if (avg != 0 && nv > 0) begin
            grey = (nv * GREY_FULL) >>> 16;
            if (grey > GREY_FULL) grey = GREY_FULL;
         end
         r.index   = idx;
         r.norm    = nv[17:0];
         r.grey    = grey[7:0];
         r.painted = avg != 0;
         expected_cells.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      cell_result_type exp_r;
      cell_result_type act_r;
      if (reset) begin
         cell_count     = 0;
         found_max      = 0;
         computed       = 0;
         radius         = 5;
         columns        = 64;
         use_ext        = 0;
         ext_max        = 0;
         mismatch_count = 0;
         expected_cells.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIUS:  radius  = csr_data[4:0];
               CSR_COLUMNS: columns = csr_data[6:0];
               CSR_USE_EXT: use_ext = csr_data[0];
               CSR_EXT_MAX: ext_max = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            act_r = rsp_tdata[38:0];
            if (expected_cells.size() == 0) begin
               $error("unexpected result item, index %0d", act_r.index);
               mismatch_count++;
            end else begin
               exp_r = expected_cells.pop_front();
               if (act_r.index !== exp_r.index) begin
                  $error("out_index: expected %0d, actual %0d", exp_r.index, act_r.index);
                  mismatch_count++;
               end
               if (act_r.norm !== exp_r.norm) begin
                  $error("normalized_value: expected %0d, actual %0d",
                         $signed(exp_r.norm), $signed(act_r.norm));
                  mismatch_count++;
               end
               if (act_r.grey !== exp_r.grey) begin
                  $error("grey_level: expected %0d, actual %0d", exp_r.grey, act_r.grey);
                  mismatch_count++;
               end
               if (act_r.painted !== exp_r.painted) begin
                  $error("painted: expected %0d, actual %0d", exp_r.painted, act_r.painted);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_LOAD) begin
               if (computed) begin
                  computed   = 0;
                  cell_count = 0;
               end
               if (cell_count < 4096) begin
                  cell_value[cell_count] = req_tdata[31:0];
                  cell_src[cell_count]   = req_tdata[32];
                  cell_count++;
               end
               if (req_tlast) spread_grid();
            end else begin
               predict_read(req_tdata[44:33]);
            end
         end
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import gwsn_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = 0;
   logic        req_tuser = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [30:0] csr_data = 0;

   int mismatch_count;
   int pending_count;
   int items_sent = 0;
   int cycle_count = 0;
   int eff_radius = 5;
   bit calm = 0;

   always #2 clock = ~clock;

   grid_weighted_spread_normalize_top dut (.*);

   gwsn_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(logic op, logic [31:0] own, logic src, logic lst, logic [11:0] idx);
      int gap;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 37 && gap < 8) gap++;
      repeat (gap) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tlast  <= lst;
      req_tdata  <= {3'b000, idx, src, own};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_cell(logic [31:0] own, logic src, logic lst);
      send_item(OP_LOAD, own, src, lst, 12'($urandom));
   endtask

   task automatic read_cell(logic [11:0] idx);
      send_item(OP_READ, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), idx);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [30:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // hold off until every expected item is back, then let the block settle
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_config(logic [4:0] r, logic [6:0] c, logic u, logic [30:0] m);
      write_csr(CSR_RADIUS, 31'(r));
      write_csr(CSR_COLUMNS, 31'(c));
      write_csr(CSR_USE_EXT, 31'(u));
      write_csr(CSR_EXT_MAX, m);
      eff_radius = r > RADIUS_CAP ? RADIUS_CAP : r;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: case ($urandom_range(4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'hffff_ffff;
               default: return 32'h0001_0000;
            endcase
         1: return 32'($urandom_range(524288)) - 32'd262144;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_grid();
      int n;
      int src_pct;
      int k;
      n = ($urandom_range(9) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
      src_pct = eff_radius > 8 ? 5 : 30;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) read_cell(12'($urandom));
         load_cell(pick_value(), $urandom_range(99) < src_pct, i == n - 1);
      end
      k = $urandom_range(1, n < 20 ? 2 * n : 30);
      repeat (k) begin
         if ($urandom_range(99) < 15) read_cell(12'($urandom));
         else read_cell(12'($urandom_range(n - 1)));
      end
      read_cell(0);
   endtask

   initial begin
      int base;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: read before any grid, extremes, reads past the grid
      read_cell(0);
      load_cell(32'h7fff_ffff, 1, 0);
      load_cell(32'h8000_0000, 0, 0);
      load_cell(32'h0, 1, 0);
      load_cell(32'hffff_ffff, 0, 0);
      load_cell(32'h0001_0000, 1, 0);
      read_cell(1);
      load_cell(32'h8000_0000, 1, 0);
      load_cell(32'h0, 0, 1);
      for (int i = 0; i < 7; i++) read_cell(12'(i));
      read_cell(12'hfff);
      load_cell(32'h1234_5678, 1, 0);
      read_cell(0);
      load_cell(32'hfffe_0000, 0, 1);
      read_cell(0);
      read_cell(1);
      drain();

      for (int p = 0; p < 6; p++) begin
         calm = (p == 2);
         case (p)
            0: set_config(16, 1, 0, 0);
            1: set_config(1, 64, 1, 31'h7fff_ffff);
            2: set_config(0, 0, 1, 0);
            3: set_config(31, 127, 1, 1);
            4: set_config(3, 8, 0, 31'($urandom));
            default: set_config(5'($urandom_range(1, 16)), 7'($urandom_range(1, 16)),
                                 1'($urandom_range(1)),
                                 $urandom_range(1) ? 31'($urandom_range(1, 1 << 20))
                                                   : 31'($urandom));
         endcase
         base = items_sent;
         while (items_sent < base + 165) random_grid();
         drain();
      end
      calm = 0;

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
